FILE: design/dmc_pkg.sv
// dmc_pkg: shared types and codes for the depth-first maze carver.
// No dependencies.
`default_nettype none
package dmc_pkg;
  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_RAND  = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam logic [1:0] ST_NEED_RAND = 2'd0;
  localparam logic [1:0] ST_FINISHED  = 2'd1;
  localparam logic [1:0] ST_READ      = 2'd2;
  localparam logic [1:0] ST_IGNORED   = 2'd3;

  localparam logic [1:0] DIR_RIGHT = 2'd0;
  localparam logic [1:0] DIR_LEFT  = 2'd1;
  localparam logic [1:0] DIR_DOWN  = 2'd2;
  localparam logic [1:0] DIR_UP    = 2'd3;

  typedef struct packed {
    logic [1:0] op;
    logic [1:0] rand_value;
    logic [4:0] read_x;
    logic [4:0] read_y;
  } in_word_t;

  typedef struct packed {
    logic [1:0] status;
    logic       cell_open;
  } out_word_t;
endpackage
`default_nettype wire

FILE: design/dmc_grid_mem.sv
// dmc_grid_mem: grid bit memory, one write and one registered read port.
// Depends on nothing.
`default_nettype none
module dmc_grid_mem #(
  parameter int unsigned AW = 10
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic          wdata_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic               rdata_o
);
  logic mem_q [2**AW];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

FILE: design/dmc_stack_mem.sv
// dmc_stack_mem: frame stack memory, one write and one registered read port.
// Depends on nothing.
`default_nettype none
module dmc_stack_mem #(
  parameter int unsigned AW = 8,
  parameter int unsigned DW = 26
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [DW-1:0] wdata_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic      [DW-1:0] rdata_o
);
  logic [DW-1:0] mem_q [2**AW];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

FILE: design/dfs_maze_carver.sv
// dfs_maze_carver: top level, sequencer over the grid and frame stack memories.
// Depends on dmc_pkg, dmc_grid_mem, dmc_stack_mem.
//
//   channel | valid   | ready   | word
//   in      | valid_i | ready_o | in_i  (dmc_pkg::in_word_t)
//   out     | valid_o | ready_i | out_o (dmc_pkg::out_word_t)
//
// A start word clears all 2**(XW+YW) grid cells (1024 by default) in a pass
// and then replies; a shuffle word replies in the cycle after accept, a read after S_READ.
// The fourth random value runs the search: a probe inside the border goes on to
// S_CHECK, one outside it back to S_PROBE, and a popped frame is read in S_FETCH.
// Reset runs the same clearing pass with ready_o low.
// One word is in flight; ready_o stays low until the result is taken.
`default_nettype none
module dfs_maze_carver #(
  parameter int unsigned GRID_W = 32,
  parameter int unsigned GRID_H = 32,
  parameter int unsigned STACK_DEPTH = 256
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                valid_i,
  output logic                     ready_o,
  input  wire dmc_pkg::in_word_t   in_i,
  output logic                     valid_o,
  input  wire logic                ready_i,
  output dmc_pkg::out_word_t       out_o
);
  localparam int unsigned XW = $clog2(GRID_W);
  localparam int unsigned YW = $clog2(GRID_H);
  localparam int unsigned GAW = XW + YW;
  localparam int unsigned SAW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned LW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned FW = XW + YW + 8 + 3;
  localparam int unsigned CW = XW + 2;
  localparam int unsigned RW = YW + 2;
  localparam logic [GAW-1:0] START_A = GAW'((1 << XW) + 1);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_READ, S_FETCH, S_PROBE, S_CHECK, S_OUT
  } state_e;

  typedef struct packed {
    logic [XW-1:0] cx;
    logic [YW-1:0] cy;
    logic [7:0]    order;
    logic [2:0]    next;
  } frame_t;

  typedef enum logic [1:0] { PH_IDLE, PH_SHUFFLE, PH_DONE } phase_e;

  state_e          state_q;
  phase_e          phase_q;
  logic [LW-1:0]   level_q;
  logic [2:0]      shuf_q;
  logic [GAW-1:0]  clr_q;
  logic            start_q;
  frame_t          top_q;
  logic [XW-1:0]   nx_q;
  logic [YW-1:0]   ny_q;
  dmc_pkg::out_word_t res_q;

  logic            g_we;
  logic            g_wdata;
  logic [GAW-1:0]  g_waddr, g_raddr;
  logic            g_rdata;
  logic            s_we;
  logic [SAW-1:0]  s_waddr, s_raddr;
  logic [FW-1:0]   s_wdata, s_rdata;

  dmc_grid_mem #(.AW(GAW)) u_grid (
    .clk_i, .we_i(g_we), .waddr_i(g_waddr), .wdata_i(g_wdata), .raddr_i(g_raddr),
    .rdata_o(g_rdata)
  );
  dmc_stack_mem #(.AW(SAW), .DW(FW)) u_stack (
    .clk_i, .we_i(s_we), .waddr_i(s_waddr), .wdata_i(s_wdata),
    .raddr_i(s_raddr), .rdata_o(s_rdata)
  );

  logic            acc;
  logic [1:0]      dir;
  logic [CW-1:0]   nxw;
  logic [RW-1:0]   nyw;
  logic            inb;
  logic [7:0]      sh_order;
  logic [1:0]      si;
  logic            ent;
  frame_t          fr;
  logic [XW-1:0]   mx;
  logic [YW-1:0]   my;

  assign acc = valid_i && ready_o;
  assign ready_o = (state_q == S_IDLE);
  assign fr = frame_t'(s_rdata);

  always_comb begin
    dir = top_q.order[2*top_q.next[1:0] +: 2];
    nxw = CW'(top_q.cx);
    nyw = RW'(top_q.cy);
    unique case (dir)
      dmc_pkg::DIR_RIGHT: nxw = CW'(top_q.cx) + CW'(2);
      dmc_pkg::DIR_LEFT:  nxw = CW'(top_q.cx) - CW'(2);
      dmc_pkg::DIR_DOWN:  nyw = RW'(top_q.cy) + RW'(2);
      default:            nyw = RW'(top_q.cy) - RW'(2);
    endcase
    inb = (nxw >= CW'(1)) && (nxw < CW'(GRID_W - 1)) &&
          (nyw >= RW'(1)) && (nyw < RW'(GRID_H - 1));
    si = shuf_q[1:0];
    sh_order = top_q.order;
    sh_order[2*si +: 2] = top_q.order[2*in_i.rand_value +: 2];
    sh_order[2*in_i.rand_value +: 2] = top_q.order[2*si +: 2];
    mx = XW'((CW'(top_q.cx) + CW'(nx_q)) >> 1);
    my = YW'((RW'(top_q.cy) + RW'(ny_q)) >> 1);
    ent = (state_q == S_CHECK) && !g_rdata && (level_q < LW'(STACK_DEPTH));
  end

  // grid read address
  always_comb begin
    if (state_q == S_PROBE) begin
      g_raddr = {YW'(nyw), XW'(nxw)};
    end else begin
      g_raddr = {YW'(in_i.read_y), XW'(in_i.read_x)};
    end
  end

  // grid write: clearing pass with the start cell, or wall plus new cell
  logic          pend_q;
  logic [GAW-1:0] pend_a_q;
  always_comb begin
    g_we = 1'b0;
    g_waddr = pend_a_q;
    g_wdata = 1'b1;
    if (state_q == S_CLEAR) begin
      g_we = 1'b1;
      g_waddr = clr_q;
      g_wdata = start_q && (clr_q == START_A);
    end else if (ent) begin
      g_we = 1'b1;
      g_waddr = {my, mx};
    end else if (pend_q) begin
      g_we = 1'b1;
    end
  end

  // stack: save the parent frame when a child is entered, fetch it on pop
  always_comb begin
    s_we = ent;
    s_waddr = SAW'(level_q - LW'(1));
    s_wdata = FW'(top_q);
    if (state_q == S_PROBE && top_q.next[2]) begin
      s_raddr = SAW'(level_q - LW'(2));
    end else begin
      s_raddr = SAW'(level_q - LW'(1));
    end
  end

  logic in_rand_ok;
  logic [4:0] rx, ry;
  assign in_rand_ok = (phase_q == PH_SHUFFLE) && (level_q != '0);
  assign rx = in_i.read_x;
  assign ry = in_i.read_y;

  logic rd_oob_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLEAR;
      phase_q  <= PH_IDLE;
      level_q  <= '0;
      shuf_q   <= '0;
      clr_q    <= '0;
      start_q  <= 1'b0;
      top_q    <= '0;
      nx_q     <= '0;
      ny_q     <= '0;
      res_q    <= '0;
      pend_q   <= 1'b0;
      pend_a_q <= '0;
      rd_oob_q <= 1'b0;
      valid_o  <= 1'b0;
    end else begin
      pend_q <= ent;
      if (ent) begin
        pend_a_q <= {ny_q, nx_q};
      end
      unique case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + GAW'(1);
          if (clr_q == '1) begin
            start_q <= 1'b0;
            valid_o <= start_q;
            state_q <= start_q ? S_OUT : S_IDLE;
          end
        end
        S_IDLE: begin
          if (acc) begin
            unique case (in_i.op)
              dmc_pkg::OP_START: begin
                level_q <= LW'(1);
                shuf_q  <= '0;
                phase_q <= PH_SHUFFLE;
                top_q   <= '{cx: XW'(1), cy: YW'(1), order: 8'hE4, next: 3'd0};
                res_q   <= '{status: dmc_pkg::ST_NEED_RAND, cell_open: 1'b0};
                clr_q   <= '0;
                start_q <= 1'b1;
                state_q <= S_CLEAR;
              end
              dmc_pkg::OP_RAND: begin
                if (in_rand_ok) begin
                  top_q.order <= sh_order;
                  shuf_q <= shuf_q + 3'd1;
                  if (shuf_q == 3'd3) begin
                    state_q <= S_PROBE;
                  end else begin
                    res_q <= '{status: dmc_pkg::ST_NEED_RAND, cell_open: 1'b0};
                    state_q <= S_OUT;
                    valid_o <= 1'b1;
                  end
                end else begin
                  res_q <= '{status: dmc_pkg::ST_IGNORED, cell_open: 1'b0};
                  state_q <= S_OUT;
                  valid_o <= 1'b1;
                end
              end
              dmc_pkg::OP_READ: begin
                rd_oob_q <= (32'(rx) >= GRID_W) || (32'(ry) >= GRID_H);
                state_q <= S_READ;
              end
              default: begin
                res_q <= '{status: dmc_pkg::ST_IGNORED, cell_open: 1'b0};
                state_q <= S_OUT;
                valid_o <= 1'b1;
              end
            endcase
          end
        end
        S_READ: begin
          res_q <= '{status: dmc_pkg::ST_READ, cell_open: g_rdata && !rd_oob_q};
          state_q <= S_OUT;
          valid_o <= 1'b1;
        end
        S_PROBE: begin
          if (top_q.next[2]) begin
            level_q <= level_q - LW'(1);
            if (level_q == LW'(1)) begin
              phase_q <= PH_DONE;
              res_q <= '{status: dmc_pkg::ST_FINISHED, cell_open: 1'b0};
              state_q <= S_OUT;
              valid_o <= 1'b1;
            end else begin
              state_q <= S_FETCH;
            end
          end else begin
            top_q.next <= top_q.next + 3'd1;
            nx_q <= XW'(nxw);
            ny_q <= YW'(nyw);
            state_q <= inb ? S_CHECK : S_PROBE;
          end
        end
        S_FETCH: begin
          top_q <= fr;
          state_q <= S_PROBE;
        end
        S_CHECK: begin
          if (ent) begin
            level_q  <= level_q + LW'(1);
            shuf_q   <= '0;
            top_q    <= '{cx: nx_q, cy: ny_q, order: 8'hE4, next: 3'd0};
            res_q    <= '{status: dmc_pkg::ST_NEED_RAND, cell_open: 1'b0};
            state_q  <= S_OUT;
            valid_o  <= 1'b1;
          end else begin
            state_q <= S_PROBE;
          end
        end
        S_OUT: begin
          if (ready_i) begin
            valid_o <= 1'b0;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_o = res_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> !ready_o)
    else $error("input taken while result pending");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_SHUFFLE && state_q == S_IDLE) |-> (level_q != '0))
    else $error("shuffling with empty stack");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (level_q <= LW'(STACK_DEPTH)))
    else $error("stack level overflow");
endmodule
`default_nettype wire
